// ===== design/dcsl_pkg.sv =====
// ============================================================================
// dcsl_pkg: shared types and constants for the DER certificate SPKI locator
// Walk phases, header steps, status codes and the result word layout.
// ============================================================================
`default_nettype none

package dcsl_pkg;

    // Walk phases, one for each structure that the walk visits.
    localparam logic [3:0] PH_OUTER     = 4'd0;
    localparam logic [3:0] PH_TBS       = 4'd1;
    localparam logic [3:0] PH_VERSION   = 4'd2;
    localparam logic [3:0] PH_SERIAL    = 4'd3;
    localparam logic [3:0] PH_SPKI      = 4'd8;
    localparam logic [3:0] PH_SPKI_BODY = 4'd9;
    localparam logic [3:0] PH_DONE      = 4'd10;

    // Steps inside one tag-length header.
    localparam logic [1:0] HS_TAG      = 2'd0;
    localparam logic [1:0] HS_TAG_MORE = 2'd1;
    localparam logic [1:0] HS_LEN      = 2'd2;
    localparam logic [1:0] HS_LEN_MORE = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_TRUNC = 3'd1;
    localparam logic [2:0] ST_TAG   = 3'd2;
    localparam logic [2:0] ST_FORM  = 3'd3;
    localparam logic [2:0] ST_SPAN  = 3'd4;
    localparam logic [2:0] ST_LONG  = 3'd5;

    // Tag numbers that the walk expects.
    localparam logic [27:0] TAG_VERSION  = 28'h00;
    localparam logic [27:0] TAG_INTEGER  = 28'h02;
    localparam logic [27:0] TAG_SEQUENCE = 28'h10;

    // Longest multi-byte tag, in continuation bytes.
    localparam logic [2:0] TAG_FOLLOW_MAX = 3'd4;

    // One result word as the walker hands it to the output register.
    typedef struct packed {
        logic [24:0] region_length;
        logic [23:0] region_offset;
        logic [2:0]  status;
    } dcsl_result_t;

    // Tag number that a given phase must carry.
    function automatic logic [27:0] expected_tag(input logic [3:0] phase);
        logic [27:0] tag;
        if (phase == PH_VERSION)
            tag = TAG_VERSION;
        else if (phase == PH_SERIAL)
            tag = TAG_INTEGER;
        else
            tag = TAG_SEQUENCE;
        return tag;
    endfunction

endpackage

`default_nettype wire

// ===== design/der_cert_spki_locator.sv =====
// ============================================================================
// der_cert_spki_locator: DER certificate public key info locator
// Walks the DER headers of a streamed certificate and reports one span.
// ============================================================================
// Usage:
//   Certificate bytes enter on the s_ stream, one byte per word, with s_tlast
//   on the final byte. Each certificate gives exactly one result word on the
//   m_ stream, issued for its last byte: status, region offset and length.
//   The cfg channel writes the selector (always ready): 0 reports the outer
//   certificate SEQUENCE, 1 the SubjectPublicKeyInfo. It is sampled when the
//   outer header completes, so write it between certificates.
// Timing:
//   One byte per cycle sustained, but a last byte waits while the result
//   word is stalled. A byte passes an input register and the header
//   walker; the result word then goes into the output register. The walker
//   updates its state once per byte, which sets that rate.
// Reset and stalls:
//   Reset empties both registers, restarts the walk and sets the selector
//   to 1. While m_tready is low, bytes that are not last keep flowing; a
//   last byte waits in the input register until any pending output word is taken.
// ============================================================================
`default_nettype none

module der_cert_spki_locator
    import dcsl_pkg::*;
#(
    parameter int POSITION_BITS    = 24,
    parameter int MAX_LENGTH_BYTES = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] cert_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [2:0] status, [26:3] region_offset,
                                        // [51:27] region_length, [55:52] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data   // selector
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    dcsl_result_t out_reg;
    logic         selector_reg;
    logic         proc;
    logic         out_free;
    dcsl_result_t walk_result;

    // A last byte needs a free output slot; other bytes never wait.
    assign out_free  = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;

    // Selector register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            selector_reg <= 1'b1;
        else if (cfg_valid)
            selector_reg <= cfg_data;
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    dcsl_walker #(
        .POSITION_BITS    (POSITION_BITS),
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (proc),
        .cert_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .selector  (selector_reg),
        .result    (walk_result)
    );

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
            out_reg <= walk_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

    // A processed last byte always yields a result word next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_last_reg) |=> m_tvalid)
        else $error("last byte processed without a result word");

    // Failed walks report an empty region.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.status != ST_OK)
            |-> (out_reg.region_offset == 24'd0 && out_reg.region_length == 25'd0))
        else $error("region reported with an error status");

    // A held last byte blocks new input while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("stalled last byte was lost");

endmodule

`default_nettype wire

// ===== design/dcsl_walker.sv =====
// ============================================================================
// dcsl_walker: DER header walker
// Takes one certificate byte per enabled cycle, tracks the tag-length headers
// and the skipped contents, and forms one result on the last byte.
// ============================================================================
`default_nettype none

module dcsl_walker
    import dcsl_pkg::*;
#(
    parameter int POSITION_BITS    = 24,
    parameter int MAX_LENGTH_BYTES = 3
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic [7:0]   cert_byte,
    input  wire logic         last_byte,
    input  wire logic         selector,
    output dcsl_result_t      result
);

    logic [3:0]               phase_reg,  phase_next;
    logic [1:0]               step_reg,   step_next;
    logic [27:0]              tag_reg,    tag_next;
    logic [2:0]               follow_reg, follow_next;
    logic                     cons_reg,   cons_next;
    logic [1:0]               lbl_reg,    lbl_next;
    logic [23:0]              clen_reg,   clen_next;
    logic [POSITION_BITS-1:0] start_reg,  start_next;
    logic [POSITION_BITS:0]   pos_reg,    pos_next;
    logic [23:0]              skip_reg,   skip_next;
    logic [23:0]              foff_reg,   foff_next;
    logic [24:0]              flen_reg,   flen_next;
    logic [2:0]               status_reg, status_next;

    // Header bookkeeping for the current byte.
    always_comb
    begin
        logic        tag_fin;
        logic [27:0] tag_val;
        logic        hdr_fin;
        logic [23:0] hdr_cl;
        logic [3:0]  tphase;
        logic [6:0]  nlen;
        logic [31:0] hlen;
        logic [31:0] start_wide;
        logic [24:0] span;
        logic [2:0]  st;

        phase_next  = phase_reg;
        step_next   = step_reg;
        tag_next    = tag_reg;
        follow_next = follow_reg;
        cons_next   = cons_reg;
        lbl_next    = lbl_reg;
        clen_next   = clen_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        skip_next   = skip_reg;
        foff_next   = foff_reg;
        flen_next   = flen_reg;
        status_next = status_reg;
        tag_fin     = 1'b0;
        tag_val     = tag_reg;
        hdr_fin     = 1'b0;
        hdr_cl      = clen_reg;
        tphase      = phase_reg;
        nlen        = cert_byte[6:0];
        hlen        = 32'(pos_reg) + 32'd1 - 32'(start_reg);
        start_wide  = 32'(start_reg);
        span        = hlen[24:0] + 25'(clen_reg);
        st          = ST_OK;
        result      = '0;

        // The byte itself: errors are sticky until the last byte.
        if (status_reg == ST_OK)
        begin
            if (pos_reg[POSITION_BITS])
                status_next = ST_LONG;
            else if (phase_reg >= PH_DONE)
                status_next = status_reg;
            else if (skip_reg != 24'd0)
                skip_next = skip_reg - 24'd1;
            else if (phase_reg == PH_SPKI_BODY)
                phase_next = PH_DONE;
            else
            begin
                unique case (step_reg)
                    HS_TAG:
                    begin
                        start_next = pos_reg[POSITION_BITS-1:0];
                        cons_next  = cert_byte[5];
                        if (cert_byte[4:0] == 5'h1f)
                        begin
                            tag_next    = '0;
                            follow_next = '0;
                            step_next   = HS_TAG_MORE;
                        end
                        else
                        begin
                            tag_val = 28'(cert_byte[4:0]);
                            tag_fin = 1'b1;
                        end
                    end
                    HS_TAG_MORE:
                    begin
                        if (follow_reg >= TAG_FOLLOW_MAX)
                            status_next = ST_LONG;
                        else
                        begin
                            tag_val     = {tag_reg[20:0], cert_byte[6:0]};
                            tag_next    = tag_val;
                            follow_next = follow_reg + 3'd1;
                            tag_fin     = !cert_byte[7];
                        end
                    end
                    HS_LEN:
                    begin
                        if (cert_byte[7])
                        begin
                            if (nlen == 7'd0)
                            begin
                                if (cons_reg)
                                    status_next = ST_FORM;
                                else
                                begin
                                    hdr_cl  = 24'd0;
                                    hdr_fin = 1'b1;
                                end
                            end
                            else if (nlen > 7'(MAX_LENGTH_BYTES))
                                status_next = ST_LONG;
                            else
                            begin
                                lbl_next  = nlen[1:0];
                                clen_next = 24'd0;
                                step_next = HS_LEN_MORE;
                            end
                        end
                        else
                        begin
                            hdr_cl  = 24'(cert_byte);
                            hdr_fin = 1'b1;
                        end
                    end
                    HS_LEN_MORE:
                    begin
                        hdr_cl    = {clen_reg[15:0], cert_byte};
                        clen_next = hdr_cl;
                        lbl_next  = lbl_reg - 2'd1;
                        hdr_fin   = (lbl_reg == 2'd1);
                    end
                    default:
                    begin
                        step_next = HS_TAG;
                    end
                endcase
            end
        end

        // Tag complete: a missing version makes this tag the serial.
        if (tag_fin)
        begin
            tag_next = tag_val;
            if (phase_reg == PH_VERSION && tag_val != TAG_VERSION)
                tphase = PH_SERIAL;
            phase_next = tphase;
            if (tag_val != expected_tag(tphase))
                status_next = ST_TAG;
            else
                step_next = HS_LEN;
        end

        // Header complete: report, descend or skip the content.
        if (hdr_fin)
        begin
            clen_next = hdr_cl;
            span      = hlen[24:0] + 25'(hdr_cl);
            step_next = HS_TAG;
            if (phase_reg == PH_OUTER)
            begin
                if (!selector)
                begin
                    foff_next  = 24'd0;
                    flen_next  = span;
                    phase_next = PH_DONE;
                end
                else
                    phase_next = PH_TBS;
            end
            else if (phase_reg == PH_TBS)
                phase_next = PH_VERSION;
            else if (phase_reg == PH_SPKI)
            begin
                foff_next  = start_wide[23:0];
                flen_next  = span;
                skip_next  = hdr_cl;
                phase_next = PH_SPKI_BODY;
            end
            else
            begin
                skip_next  = hdr_cl;
                phase_next = phase_reg + 4'd1;
            end
        end

        // Position counter saturates one past the largest legal offset.
        if (!pos_reg[POSITION_BITS])
            pos_next = pos_reg + 1'b1;

        // Status of the certificate as it stands after this byte.
        if (status_next != ST_OK)
            st = status_next;
        else if (phase_next == PH_DONE)
            st = ST_OK;
        else if (phase_next == PH_SPKI_BODY)
            st = ST_SPAN;
        else
            st = ST_TRUNC;
        result.status = st;
        if (st == ST_OK)
        begin
            result.region_offset = foff_next;
            result.region_length = flen_next;
        end

        // The last byte restarts the walk for the next certificate.
        if (last_byte)
        begin
            phase_next  = PH_OUTER;
            step_next   = HS_TAG;
            tag_next    = '0;
            follow_next = '0;
            cons_next   = 1'b0;
            lbl_next    = '0;
            clen_next   = '0;
            start_next  = '0;
            pos_next    = '0;
            skip_next   = '0;
            foff_next   = '0;
            flen_next   = '0;
            status_next = ST_OK;
        end
    end

    // Walk state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OUTER;
            step_reg   <= HS_TAG;
            tag_reg    <= '0;
            follow_reg <= '0;
            cons_reg   <= 1'b0;
            lbl_reg    <= '0;
            clen_reg   <= '0;
            start_reg  <= '0;
            pos_reg    <= '0;
            skip_reg   <= '0;
            foff_reg   <= '0;
            flen_reg   <= '0;
            status_reg <= ST_OK;
        end
        else if (en)
        begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            tag_reg    <= tag_next;
            follow_reg <= follow_next;
            cons_reg   <= cons_next;
            lbl_reg    <= lbl_next;
            clen_reg   <= clen_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            skip_reg   <= skip_next;
            foff_reg   <= foff_next;
            flen_reg   <= flen_next;
            status_reg <= status_next;
        end
    end

    // An error, once set, holds until the certificate ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && !last_byte && status_reg != ST_OK) |=> status_reg == $past(status_reg))
        else $error("walk status changed after an error");

    // Content is skipped only once a header below the outer level is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (skip_reg != 24'd0) |-> (phase_reg >= PH_SERIAL && phase_reg <= PH_SPKI_BODY))
        else $error("skip count pending in a phase that skips nothing");

    // Every byte advances the position until a last byte clears it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && last_byte) |=> pos_reg == '0)
        else $error("position not cleared after the last byte");

endmodule

`default_nettype wire

// ===== tb/dcsl_span_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// dcsl_span_checker: result checker for the DER certificate SPKI locator
// Watches the byte, result and selector channels. Predicts the status and
// span for each certificate from the accepted bytes and compares every
// result word against the oldest prediction.
// ============================================================================

module dcsl_span_checker
    import dcsl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] cert_byte
    input  wire logic        s_tlast,   // last_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,   // [2:0] status, [26:3] region_offset,
                                        // [51:27] region_length, [55:52] zero
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,  // selector
    output int               span_errors,
    output int               spans_owed
);

    localparam int POS_BITS      = 24;
    localparam int MAX_LEN_BYTES = 3;

    // Selector copy and walk state of the predicted header walker.
    logic                sel;
    logic [3:0]          phase;
    logic [1:0]          hstep;
    logic [27:0]         tag_num;
    logic [2:0]          tag_follow;
    logic                constr;
    logic [1:0]          len_left;
    logic [23:0]         content_len;
    logic [POS_BITS:0]   hdr_start;
    logic [POS_BITS:0]   byte_pos;
    logic [23:0]         skip_cnt;
    logic [23:0]         found_off;
    logic [24:0]         found_len;
    logic [2:0]          walk_st;

    // Predicted result words, oldest first.
    dcsl_result_t        predicted_spans[$];

    // Every certificate starts from a clean walk.
    function automatic void clear_walk();
        phase       = PH_OUTER;
        hstep       = HS_TAG;
        tag_num     = '0;
        tag_follow  = '0;
        constr      = 1'b0;
        len_left    = '0;
        content_len = '0;
        hdr_start   = '0;
        byte_pos    = '0;
        skip_cnt    = '0;
        found_off   = '0;
        found_len   = '0;
        walk_st     = ST_OK;
    endfunction

    // A complete tag moves on to the length, or flags a tag mismatch.
    // A tag other than zero at the version place is taken as the serial tag.
    task automatic close_tag();
        logic [27:0] wanted;
        if (phase == PH_VERSION && tag_num != TAG_VERSION)
            phase = PH_SERIAL;
        case (phase)
            PH_VERSION: wanted = TAG_VERSION;
            PH_SERIAL:  wanted = TAG_INTEGER;
            default:    wanted = TAG_SEQUENCE;
        endcase
        if (tag_num != wanted)
            walk_st = ST_TAG;
        else
            hstep = HS_LEN;
    endtask

    // A complete header either reports a span, enters a sequence or starts
    // skipping the content of a field.
    task automatic close_header(input logic [POS_BITS:0] pos);
        logic [31:0] span;
        span  = 32'(pos) + 32'd1 - 32'(hdr_start) + 32'(content_len);
        hstep = HS_TAG;
        if (phase == PH_OUTER) begin
            if (!sel) begin
                found_off = '0;
                found_len = span[24:0];
                phase     = PH_DONE;
            end
            else
            begin
                phase = PH_TBS;
            end
        end
        else if (phase == PH_TBS) begin
            phase = PH_VERSION;
        end
        else if (phase == PH_SPKI) begin
            found_off = hdr_start[23:0];
            found_len = span[24:0];
            skip_cnt  = content_len;
            phase     = PH_SPKI_BODY;
        end
        else
        begin
            skip_cnt = content_len;
            phase    = phase + 4'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dcsl_result_t seen;
        dcsl_result_t want;
        logic [6:0]   len_code;
        logic [2:0]   st;
        if (!rst_n) begin
            sel = 1'b1;
            clear_walk();
            predicted_spans.delete();
            span_errors = 0;
        end
        else
        begin
            // A selector write applies to the next certificate header.
            if (cfg_valid && cfg_ready)
                sel = cfg_data;

            // Check each result word against the oldest prediction.
            if (m_tvalid && m_tready) begin
                seen = m_tdata[51:0];
                if (m_tdata[55:52] != 4'd0) begin
                    $error("pad bits: expected 0, got %0h", m_tdata[55:52]);
                    span_errors++;
                end
                if (predicted_spans.size() == 0) begin
                    $error("result word %h with no certificate outstanding", m_tdata);
                    span_errors++;
                end
                else
                begin
                    want = predicted_spans.pop_front();
                    if (seen.status != want.status) begin
                        $error("status field: expected %0d, got %0d",
                               want.status, seen.status);
                        span_errors++;
                    end
                    if (seen.region_offset != want.region_offset) begin
                        $error("region_offset: expected %0d, got %0d",
                               want.region_offset, seen.region_offset);
                        span_errors++;
                    end
                    if (seen.region_length != want.region_length) begin
                        $error("region_length: expected %0d, got %0d",
                               want.region_length, seen.region_length);
                        span_errors++;
                    end
                end
            end

            // Walk one certificate byte. The first error sticks until the
            // last byte.
            if (s_tvalid && s_tready) begin
                len_code = s_tdata[6:0];
                if (walk_st == ST_OK) begin
                    if (byte_pos[POS_BITS]) begin
                        walk_st = ST_LONG;
                    end
                    else if (phase >= PH_DONE) begin
                        // Bytes after the reported structure are ignored.
                    end
                    else if (skip_cnt != 0) begin
                        skip_cnt = skip_cnt - 24'd1;
                    end
                    else if (phase == PH_SPKI_BODY) begin
                        phase = PH_DONE;
                    end
                    else
                    begin
                        case (hstep)
                            HS_TAG:
                            begin
                                hdr_start = byte_pos;
                                constr    = s_tdata[5];
                                if (s_tdata[4:0] == 5'h1f) begin
                                    tag_num    = '0;
                                    tag_follow = '0;
                                    hstep      = HS_TAG_MORE;
                                end
                                else
                                begin
                                    tag_num = 28'(s_tdata[4:0]);
                                    close_tag();
                                end
                            end
                            HS_TAG_MORE:
                            begin
                                if (tag_follow >= TAG_FOLLOW_MAX) begin
                                    walk_st = ST_LONG;
                                end
                                else
                                begin
                                    tag_num    = {tag_num[20:0], s_tdata[6:0]};
                                    tag_follow = tag_follow + 3'd1;
                                    if (!s_tdata[7])
                                        close_tag();
                                end
                            end
                            HS_LEN:
                            begin
                                if (!s_tdata[7]) begin
                                    content_len = 24'(s_tdata);
                                    close_header(byte_pos);
                                end
                                else if (len_code == 7'd0) begin
                                    // Indefinite length: only a primitive
                                    // tag may carry it, meaning empty.
                                    if (constr) begin
                                        walk_st = ST_FORM;
                                    end
                                    else
                                    begin
                                        content_len = '0;
                                        close_header(byte_pos);
                                    end
                                end
                                else if (len_code > 7'(MAX_LEN_BYTES)) begin
                                    walk_st = ST_LONG;
                                end
                                else
                                begin
                                    len_left    = len_code[1:0];
                                    content_len = '0;
                                    hstep       = HS_LEN_MORE;
                                end
                            end
                            default:
                            begin
                                content_len = {content_len[15:0], s_tdata};
                                len_left    = len_left - 2'd1;
                                if (len_left == 2'd0)
                                    close_header(byte_pos);
                            end
                        endcase
                    end
                end
                if (!byte_pos[POS_BITS])
                    byte_pos = byte_pos + 1'b1;

                // The last byte closes the certificate with one result.
                if (s_tlast) begin
                    if (walk_st != ST_OK)
                        st = walk_st;
                    else if (phase == PH_DONE)
                        st = ST_OK;
                    else if (phase == PH_SPKI_BODY)
                        st = ST_SPAN;
                    else
                        st = ST_TRUNC;
                    want.status        = st;
                    want.region_offset = (st == ST_OK) ? found_off : '0;
                    want.region_length = (st == ST_OK) ? found_len : '0;
                    predicted_spans.push_back(want);
                    clear_walk();
                end
            end
        end
        spans_owed = predicted_spans.size();
    end

endmodule

// ===== tb/der_cert_spki_locator_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// der_cert_spki_locator_tb: stimulus and verdict for the SPKI locator
// Streams directed and random DER certificates through the block under both
// selector settings and several idle patterns on the byte and result
// streams. A checker beside the block predicts and compares every result.
// ============================================================================

module der_cert_spki_locator_tb;

    localparam int QUIET_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] cert_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [2:0] status, [26:3] region_offset,
                            // [51:27] region_length, [55:52] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;  // selector

    int          span_errors;
    int          spans_owed;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    int          quiet_cycles = 0;

    // Bytes of the certificate being built or sent.
    logic [7:0]  frame_q[$];

    der_cert_spki_locator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dcsl_span_checker span_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .span_errors (span_errors),
        .spans_owed  (spans_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side stalls at random with the current stall rate.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // End the run when no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one byte after an optional random gap and wait for it to be taken.
    // Called at a falling edge; valid stays high on return.
    task automatic push_byte(input logic [7:0] b, input logic lst);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            push_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Write the selector; only done while no certificate is in flight.
    task automatic write_selector(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every certificate has its result, then let the pipeline
    // drain a little further.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (spans_owed != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Append a tag and length header with random class bits and a random
    // but valid choice among the short, multi-byte and long encodings.
    task automatic emit_header(input int num, input logic cons, input int n);
        logic [1:0] cls;
        int         k;
        cls = 2'($urandom_range(0, 3));
        if (num < 31 && $urandom_range(0, 3) != 0) begin
            frame_q.push_back({cls, cons, 5'(num)});
        end
        else
        begin
            frame_q.push_back({cls, cons, 5'h1f});
            if ($urandom_range(0, 3) == 0)
                frame_q.push_back(8'h80);
            frame_q.push_back({1'b0, 7'(num)});
        end
        if (n == 0 && !cons && $urandom_range(0, 3) == 0) begin
            frame_q.push_back(8'h80);
        end
        else
        begin
            k = 0;
            if (n >= 128 || $urandom_range(0, 2) == 0)
                k = $urandom_range((n < 256) ? 1 : 2, 3);
            if (k == 0) begin
                frame_q.push_back(8'(n));
            end
            else
            begin
                frame_q.push_back(8'(8'h80 + k));
                for (int i = k - 1; i >= 0; i--)
                    frame_q.push_back(8'(n >> (8 * i)));
            end
        end
    endtask

    task automatic emit_tlv(input int num, input logic cons, input int n);
        emit_header(num, cons, n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    // Build one random certificate: mostly well formed with random content,
    // the rest truncated, corrupted or plain noise.
    task automatic build_random_frame();
        int         kind;
        int         cut;
        int         trail;
        logic [7:0] body[$];
        logic [7:0] tbs_hdr[$];
        kind = $urandom_range(0, 99);
        frame_q.delete();
        if (kind >= 90) begin
            repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom));
            if (kind[0])
                frame_q[0] = 8'h30;
        end
        else
        begin
            // TBS body: optional version, serial, four sequences, then SPKI.
            if ($urandom_range(0, 2) != 0) begin
                emit_header(0, 1'b1, 3);
                frame_q.push_back(8'h02);
                frame_q.push_back(8'h01);
                frame_q.push_back(8'($urandom_range(0, 2)));
            end
            emit_tlv(2, 1'b0, $urandom_range(0, 4));
            repeat (4) emit_tlv(16, 1'b1, $urandom_range(0, 6));
            emit_tlv(16, 1'b1, $urandom_range(0, 8));
            body = frame_q;
            frame_q.delete();
            emit_header(16, 1'b1, body.size());
            tbs_hdr = frame_q;
            frame_q.delete();

            // Trailing bytes after the TBS; none means the stream ends on
            // the last byte of the key info.
            trail = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 4);
            emit_header(16, 1'b1, tbs_hdr.size() + body.size() + trail);
            foreach (tbs_hdr[i])
                frame_q.push_back(tbs_hdr[i]);
            foreach (body[i])
                frame_q.push_back(body[i]);
            repeat (trail) frame_q.push_back(8'($urandom));

            if (kind >= 80) begin
                frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom);
            end
            else if (kind >= 65) begin
                cut = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
        end
    endtask

    initial
    begin
        int phase_bytes;
        int phase_frames;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed certificates, key info selected.
        write_selector(1'b1);
        // Full walk with version and one trailing byte.
        frame_q = '{8'h30, 8'h1a, 8'h30, 8'h14, 8'ha0, 8'h03, 8'h02, 8'h01, 8'h02,
                    8'h02, 8'h01, 8'h05, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
                    8'h30, 8'h00, 8'h30, 8'h02, 8'h05, 8'h00, 8'h00};
        send_frame();
        // No version, empty primitive with indefinite length, multi-byte
        // tag and long-form lengths.
        frame_q = '{8'h30, 8'h81, 8'h14, 8'h30, 8'h11, 8'h02, 8'h80, 8'h3f, 8'h10,
                    8'h00, 8'h30, 8'h81, 8'h01, 8'haa, 8'h30, 8'h82, 8'h00, 8'h00,
                    8'h30, 8'h00, 8'h30, 8'h83, 8'h00, 8'h00, 8'h01, 8'hff, 8'h01};
        send_frame();
        // Stream ends on the final byte of the key info.
        frame_q = '{8'h30, 8'h10, 8'h30, 8'h0e, 8'h02, 8'h01, 8'h01, 8'h30, 8'h00,
                    8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h01, 8'hff};
        send_frame();
        // Version tag with four continuation bytes, then cut inside serial.
        frame_q = '{8'h30, 8'h0c, 8'h30, 8'h0a, 8'hbf, 8'h80, 8'h80, 8'h80, 8'h00,
                    8'h03, 8'h02, 8'h01, 8'h02, 8'h02, 8'h02, 8'h01};
        send_frame();
        // Tag with a fifth continuation byte.
        frame_q = '{8'h30, 8'h03, 8'h30, 8'h01, 8'h3f, 8'h81, 8'h81, 8'h81, 8'h81,
                    8'h01};
        send_frame();
        // Indefinite length on a constructed tag; later bytes are ignored.
        frame_q = '{8'h30, 8'h80, 8'h00, 8'h00};
        send_frame();
        // Four length bytes.
        frame_q = '{8'h30, 8'h84, 8'h00, 8'h00, 8'h00, 8'h10};
        send_frame();
        // Wrong outer tag, then wrong serial tag.
        frame_q = '{8'h31, 8'h00};
        send_frame();
        frame_q = '{8'h30, 8'h06, 8'h30, 8'h04, 8'h04, 8'h01, 8'h00, 8'hff};
        send_frame();
        // Streams of one byte end before any header completes.
        frame_q = '{8'h30};
        send_frame();
        frame_q = '{8'hff};
        send_frame();
        settle();

        // Directed certificates, whole span selected.
        write_selector(1'b0);
        // Largest content length gives the largest span.
        frame_q = '{8'h30, 8'h83, 8'hff, 8'hff, 8'hff, 8'h00};
        send_frame();
        frame_q = '{8'h30, 8'h00};
        send_frame();
        // Content of the outer sequence is not examined.
        frame_q = '{8'h30, 8'h82, 8'h01, 8'h00, 8'hff, 8'hff, 8'h31};
        send_frame();
        frame_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        send_frame();
        settle();

        // Random certificates: each idle pattern under both selector values.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph / 2)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 53; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 9;  stall_pct = 9;  end
            endcase
            write_selector(ph[0]);
            phase_bytes  = 0;
            phase_frames = 0;
            while (phase_bytes < 72 || phase_frames < 2) begin
                build_random_frame();
                send_frame();
                phase_bytes  += frame_q.size();
                phase_frames++;
            end
            settle();
        end

        if (span_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
